@@ rtl/mu8_pkg.sv @@
// Types and constants shared by the modified UTF-8 decoder files.
`timescale 1ns / 1ps
`default_nettype none
package mu8_pkg;

	// Decoder phase, one-hot
	typedef enum logic [2:0] {
		PH_LEAD = 3'b001,  // expecting a lead byte
		PH_LAST = 3'b010,  // expecting the final continuation byte
		PH_MID  = 3'b100   // expecting the middle byte of a three-byte form
	} phase_t;

	localparam logic [15:0] INVALID_UNIT = 16'h003F;
	localparam logic [15:0] MAX_COUNT    = 16'hFFFF;

	// Per-string decoder state; partial holds the bits of a character above its final six
	typedef struct packed {
		phase_t      phase;
		logic [9:0]  partial;
		logic [15:0] count;
		logic        skip;
	} mu8_state_t;

	// One result word
	typedef struct packed {
		logic [15:0] code_unit;
		logic        unit_valid;
		logic        string_done;
		logic [15:0] char_count;
	} mu8_result_t;

endpackage
`default_nettype wire

@@ rtl/mu8_in_if.sv @@
// Byte channel into the decoder.
`timescale 1ns / 1ps
`default_nettype none
interface mu8_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_byte;

	modport source (output valid, output in_byte, output last_byte, input ready);
	modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/mu8_out_if.sv @@
// Code unit channel out of the decoder.
`timescale 1ns / 1ps
`default_nettype none
interface mu8_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        unit_valid;
	logic        string_done;
	logic [15:0] char_count;

	modport source (output valid, output code_unit, output unit_valid,
		output string_done, output char_count, input ready);
	modport sink   (input valid, input code_unit, input unit_valid,
		input string_done, input char_count, output ready);
endinterface
`default_nettype wire

@@ rtl/mu8_decode.sv @@
// Next-state and result logic for one byte of a modified UTF-8 string.
`timescale 1ns / 1ps
`default_nettype none
module mu8_decode (
	input  var mu8_pkg::mu8_state_t  cur,
	input  var logic [7:0]           in_byte,
	input  var logic                 last_byte,
	output var mu8_pkg::mu8_state_t  nxt,
	output var logic                 emit,
	output var mu8_pkg::mu8_result_t res
);
	import mu8_pkg::*;

	logic        have_unit;
	logic [15:0] unit;
	logic [15:0] count_inc;
	mu8_state_t  work;

	// Decode the byte against the current phase
	always_comb begin
		have_unit = 1'b0;
		unit      = 16'h0000;
		work      = cur;
		unique case (cur.phase) inside
			PH_LAST, PH_MID: begin
				if (in_byte > 8'hBF) begin
					unit         = INVALID_UNIT;
					have_unit    = 1'b1;
					work.phase   = PH_LEAD;
					work.partial = 10'd0;
				end else if (cur.phase == PH_MID) begin
					work.partial = cur.partial | {4'd0, in_byte[5:0]};
					work.phase   = PH_LAST;
				end else begin
					unit         = {cur.partial, in_byte[5:0]};
					have_unit    = 1'b1;
					work.phase   = PH_LEAD;
					work.partial = 10'd0;
				end
			end
			default: begin
				work.phase = PH_LEAD;
				if (!in_byte[7]) begin
					unit      = {8'h00, in_byte};
					have_unit = 1'b1;
				end else if (in_byte < 8'hC0) begin
					unit      = INVALID_UNIT;
					have_unit = 1'b1;
				end else if (in_byte < 8'hE0) begin
					work.partial = {5'd0, in_byte[4:0]};
					work.phase   = PH_LAST;
				end else if (in_byte < 8'hF0) begin
					work.partial = {in_byte[3:0], 6'd0};
					work.phase   = PH_MID;
				end else begin
					unit      = INVALID_UNIT;
					have_unit = 1'b1;
				end
			end
		endcase
	end

	// Count characters, saturating
	assign count_inc = (have_unit && cur.count < MAX_COUNT) ? cur.count + 16'd1 : cur.count;

	// Pick result and next state, with skip and zero-byte handling on top
	always_comb begin
		nxt             = work;
		nxt.count       = count_inc;
		emit            = have_unit || last_byte;
		res.code_unit   = have_unit ? unit : 16'h0000;
		res.unit_valid  = have_unit;
		res.string_done = last_byte;
		res.char_count  = last_byte ? count_inc : 16'h0000;
		if (last_byte) begin
			nxt.phase   = PH_LEAD;
			nxt.partial = 10'd0;
			nxt.count   = 16'h0000;
			nxt.skip    = 1'b0;
		end
		if (cur.skip) begin
			emit = 1'b0;
			nxt  = cur;
			if (last_byte) begin
				nxt.phase   = PH_LEAD;
				nxt.partial = 10'd0;
				nxt.count   = 16'h0000;
				nxt.skip    = 1'b0;
			end
		end else if (in_byte == 8'h00) begin
			emit            = 1'b1;
			res.code_unit   = 16'h0000;
			res.unit_valid  = 1'b0;
			res.string_done = 1'b1;
			res.char_count  = cur.count;
			nxt.phase       = PH_LEAD;
			nxt.partial     = 10'd0;
			nxt.count       = 16'h0000;
			nxt.skip        = !last_byte;
		end
	end

endmodule
`default_nettype wire

@@ rtl/modified_utf8_to_utf16_decoder_unit.sv @@
// A byte goes from the input register through the decode logic into the output register.
// Throughput: one byte per cycle, stalled only by an untaken word in the output register.
// A byte waits in the input register only while the output register holds an untaken word.
// Bytes that complete no character and do not end the string give no word.
// Reset (arst_n low, asynchronous) empties both registers and restarts the string.
// Decoder top level: input register, decode logic, output register.
`timescale 1ns / 1ps
`default_nettype none
module modified_utf8_to_utf16_decoder_unit (
	input  var logic  clk,
	input  var logic  arst_n,
	mu8_in_if.sink    in_ch,
	mu8_out_if.source out_ch
);
	import mu8_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	mu8_state_t  state_q;
	mu8_state_t  state_nxt;
	logic        emit;
	mu8_result_t res;
	logic        out_valid_q;
	mu8_result_t out_q;
	logic        out_free;
	logic        s1_go;

	mu8_decode u_decode (
		.cur       (state_q),
		.in_byte   (byte_s1),
		.last_byte (last_s1),
		.nxt       (state_nxt),
		.emit      (emit),
		.res       (res)
	);

	assign out_free    = !out_valid_q || out_ch.ready;
	assign s1_go       = valid_s1 && (!emit || out_free);
	assign in_ch.ready = !valid_s1 || s1_go;

	// Capture the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	// Advance the decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase   <= PH_LEAD;
			state_q.partial <= 10'd0;
			state_q.count   <= 16'h0000;
			state_q.skip    <= 1'b0;
		end else if (s1_go) begin
			state_q <= state_nxt;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_go && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_go && emit) begin
			out_q <= res;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.code_unit   = out_q.code_unit;
	assign out_ch.unit_valid  = out_q.unit_valid;
	assign out_ch.string_done = out_q.string_done;
	assign out_ch.char_count  = out_q.char_count;

endmodule
`default_nettype wire

@@ rtl/mu8_checker.sv @@
// Port-level checks on the decoder and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mu8_checker (
	input var logic        clk,
	input var logic        arst_n,
	input var logic        out_valid,
	input var logic        out_ready,
	input var logic [15:0] code_unit,
	input var logic        unit_valid,
	input var logic        string_done,
	input var logic [15:0] char_count
);

	// Hold a stalled word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(code_unit) && $stable(char_count)
			&& $stable(unit_valid) && $stable(string_done))
		else $error("output word changed while stalled");

	// Every word carries a character or ends a string
	a_word_meaning: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> unit_valid || string_done)
		else $error("empty output word");

	a_unit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !unit_valid |-> code_unit == 16'h0000)
		else $error("code unit set without a character");

	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !string_done |-> char_count == 16'h0000)
		else $error("count set before the string ends");

endmodule

bind modified_utf8_to_utf16_decoder_unit mu8_checker u_mu8_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.code_unit   (out_ch.code_unit),
	.unit_valid  (out_ch.unit_valid),
	.string_done (out_ch.string_done),
	.char_count  (out_ch.char_count)
);
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the modified UTF-8 to UTF-16 decoder unit.
`timescale 1ns / 1ps
module testbench;
	import mu8_pkg::*;

	localparam int unsigned LONG_HOLD    = 400;     // receiver hold-off, in cycles
	localparam int unsigned LONG_STRING  = 300;     // one-byte characters, back to back
	localparam int unsigned RANDOM_BYTES = 1650;    // live random bytes to generate
	localparam int unsigned SETTLE       = 10;      // cycles after the last word

	typedef struct {
		logic [7:0]  data;
		logic        last;
		int unsigned gap;
		bit          drain;
	} byte_item_t;

	logic clk = 1'b0;
	logic arst_n;

	mu8_in_if  in_ch ();
	mu8_out_if out_ch ();

	modified_utf8_to_utf16_decoder_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Free-running 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Bytes waiting to be offered and results waiting to be seen
	byte_item_t  byte_q[$];
	mu8_result_t expected_words[int];
	int unsigned words_predicted = 0;
	int unsigned words_checked   = 0;
	int unsigned bytes_sent      = 0;
	int unsigned total_bytes     = 0;
	int unsigned random_bytes    = 0;
	int unsigned strings_total   = 0;
	int unsigned fail_count      = 0;
	logic [8:0]  directed_bytes [0:24];

	// Decoder state as the predictor sees it
	phase_t      dec_phase   = PH_LEAD;
	logic [15:0] dec_partial = '0;
	logic [15:0] dec_count   = '0;
	bit          dec_skip    = 1'b0;

	function automatic void clear_decoder();
		dec_phase   = PH_LEAD;
		dec_partial = '0;
		dec_count   = '0;
		dec_skip    = 1'b0;
	endfunction

	// Advance the decoder by one byte; return 1 when the byte yields a word
	function automatic bit decode_byte(input logic [7:0] b, input logic last,
			output mu8_result_t word);
		bit          have;
		logic [15:0] unit;
		word = '0;
		have = 1'b0;
		unit = '0;
		// after a zero byte, drop everything up to the last byte
		if (dec_skip) begin
			if (last)
				clear_decoder();
			return 1'b0;
		end
		// zero byte ends the string at once
		if (b == 8'h00) begin
			word.string_done = 1'b1;
			word.char_count  = dec_count;
			clear_decoder();
			dec_skip = !last;
			return 1'b1;
		end
		case (dec_phase) inside
			PH_LAST, PH_MID: begin
				if (b > 8'hBF) begin
					unit        = INVALID_UNIT;
					have        = 1'b1;
					dec_phase   = PH_LEAD;
					dec_partial = '0;
				end else if (dec_phase == PH_MID) begin
					dec_partial = dec_partial | {4'b0, b[5:0], 6'b0};
					dec_phase   = PH_LAST;
				end else begin
					unit        = dec_partial | {10'b0, b[5:0]};
					have        = 1'b1;
					dec_phase   = PH_LEAD;
					dec_partial = '0;
				end
			end
			default: begin
				dec_phase = PH_LEAD;
				if (b <= 8'h7F) begin
					unit = {8'h00, b};
					have = 1'b1;
				end else if (b < 8'hC0) begin
					unit = INVALID_UNIT;
					have = 1'b1;
				end else if (b < 8'hE0) begin
					dec_partial = {5'b0, b[4:0], 6'b0};
					dec_phase   = PH_LAST;
				end else if (b < 8'hF0) begin
					dec_partial = {b[3:0], 12'b0};
					dec_phase   = PH_MID;
				end else begin
					unit = INVALID_UNIT;
					have = 1'b1;
				end
			end
		endcase
		if (have && dec_count != MAX_COUNT)
			dec_count = dec_count + 16'd1;
		if (!have && !last)
			return 1'b0;
		word.code_unit   = unit;
		word.unit_valid  = have;
		word.string_done = last;
		word.char_count  = last ? dec_count : 16'd0;
		if (last)
			clear_decoder();
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: word %0d %s mismatch: expected %h, got %h",
				$time, words_checked, name, want, got);
			fail_count++;
		end
	endfunction

	// Sender gap for one byte by traffic mode: random, back to back, or bursty
	function automatic int unsigned draw_gap(input int unsigned mode);
		case (mode)
			0: return $urandom_range(0, 15);
			1: return 0;
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
		endcase
	endfunction

	function automatic logic [7:0] cont_byte();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	function automatic logic [7:0] lead_byte();
		return 8'($urandom_range(8'hC0, 8'hEF));
	endfunction

	task automatic add_byte(input logic [7:0] data, input logic last, input int unsigned gap,
			input bit drain);
		byte_q.push_back('{data, last, gap, drain});
		if (last)
			strings_total++;
	endtask

	// Build one string: mostly well-formed characters, the rest broken forms and noise
	task automatic add_random_string(input int unsigned mode, input bit drain_first);
		logic [7:0]  body[$];
		logic [7:0]  lead;
		int unsigned nchars;
		int unsigned pick;
		bit          seen_zero;
		nchars    = $urandom_range(1, 8);
		seen_zero = 1'b0;
		for (int i = 0; i < nchars; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				body.push_back(8'($urandom_range(1, 127)));
			end else if (pick < 50) begin
				body.push_back(8'($urandom_range(8'hC0, 8'hDF)));
				body.push_back(cont_byte());
			end else if (pick < 70) begin
				body.push_back(8'($urandom_range(8'hE0, 8'hEF)));
				body.push_back(cont_byte());
				body.push_back(cont_byte());
			end else if (pick < 80) begin
				body.push_back(8'($urandom_range(0, 255)));
			end else if (pick < 84) begin
				body.push_back(8'h00);
			end else if (pick < 90) begin
				// continuation above 0xBF, at the middle or the final position
				case ($urandom_range(0, 2))
					0: body.push_back(8'($urandom_range(8'hC0, 8'hDF)));
					1: body.push_back(8'($urandom_range(8'hE0, 8'hEF)));
					default: begin
						body.push_back(8'($urandom_range(8'hE0, 8'hEF)));
						body.push_back(cont_byte());
					end
				endcase
				body.push_back(8'($urandom_range(8'hC0, 8'hFF)));
			end else if (pick < 95) begin
				// continuation below 0x80 is taken for its low bits
				lead = lead_byte();
				body.push_back(lead);
				body.push_back(8'($urandom_range(1, 127)));
				if (lead >= 8'hE0)
					body.push_back(8'($urandom_range(1, 255)));
			end else begin
				body.push_back(lead_byte());
			end
		end
		foreach (body[k]) begin
			if (!seen_zero)
				random_bytes++;
			if (body[k] == 8'h00)
				seen_zero = 1'b1;
			add_byte(body[k], k == body.size() - 1, draw_gap(mode), drain_first && k == 0);
		end
	endtask

	// Driver: predict each accepted byte, then offer the next one
	mu8_result_t drv_word;
	bit          drv_made;
	byte_item_t  drv_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid     <= 1'b0;
			in_ch.in_byte   <= 8'h00;
			in_ch.last_byte <= 1'b0;
		end else begin
			drv_made = 1'b0;
			if (in_ch.valid && in_ch.ready) begin
				drv_made = decode_byte(in_ch.in_byte, in_ch.last_byte, drv_word);
				if (drv_made) begin
					expected_words[words_predicted] = drv_word;
					words_predicted <= words_predicted + 1;
				end
				bytes_sent <= bytes_sent + 1;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (byte_q.size() == 0) begin
					in_ch.valid <= 1'b0;
				end else if (byte_q[0].drain &&
						(drv_made || words_predicted != words_checked)) begin
					// hold until every outstanding word is back
					in_ch.valid <= 1'b0;
				end else if (byte_q[0].gap != 0) begin
					byte_q[0].drain = 1'b0;
					byte_q[0].gap   = byte_q[0].gap - 1;
					in_ch.valid <= 1'b0;
				end else begin
					drv_item = byte_q.pop_front();
					in_ch.valid     <= 1'b1;
					in_ch.in_byte   <= drv_item.data;
					in_ch.last_byte <= drv_item.last;
				end
			end
		end
	end

	// Monitor: check each taken word against the oldest expectation, then stall at random
	int unsigned hold_left = 0;
	int unsigned hold_draw;
	mu8_result_t mon_want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_left    <= 1;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (words_checked >= words_predicted) begin
					$display("%0t: unexpected word: expected none, got code_unit %h unit_valid %b",
						$time, out_ch.code_unit, out_ch.unit_valid);
					$display("%0t:   string_done %b char_count %h", $time,
						out_ch.string_done, out_ch.char_count);
					fail_count++;
				end else begin
					mon_want = expected_words[words_checked];
					check_field("code_unit", mon_want.code_unit, out_ch.code_unit);
					check_field("unit_valid", 16'(mon_want.unit_valid), 16'(out_ch.unit_valid));
					check_field("string_done", 16'(mon_want.string_done),
						16'(out_ch.string_done));
					check_field("char_count", mon_want.char_count, out_ch.char_count);
					expected_words.delete(words_checked);
					words_checked <= words_checked + 1;
				end
				// long hold-off at word 100 of every 32768, calm and random stretches of 256 words in turn
				if ((words_checked % 32768) == 100)
					hold_draw = LONG_HOLD;
				else if (((words_checked / 256) % 2) == 1)
					hold_draw = 0;
				else
					hold_draw = $urandom_range(0, 15);
				out_ch.ready <= (hold_draw == 0);
				hold_left    <= hold_draw;
			end else if (hold_left != 0) begin
				out_ch.ready <= (hold_left == 1);
				hold_left    <= hold_left - 1;
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		in_ch.valid     = 1'b0;
		in_ch.in_byte   = 8'h00;
		in_ch.last_byte = 1'b0;
		out_ch.ready    = 1'b0;
		arst_n          = 1'b0;

		// bit 8 marks the last byte of a string
		directed_bytes = '{
			9'h001, 9'h07F, 9'h080, 9'h0F0, 9'h0FF, 9'h1BF,
			9'h0C0, 9'h080, 9'h0EF, 9'h0BF, 9'h0BF, 9'h0E1, 9'h085, 9'h0FF,
			9'h0C2, 9'h0C0, 9'h0C3, 9'h041, 9'h0E2, 9'h182,
			9'h041, 9'h000, 9'h0C2, 9'h1E1,
			9'h100
		};
		foreach (directed_bytes[i])
			add_byte(directed_bytes[i][7:0], directed_bytes[i][8], draw_gap(0), 1'b0);

		// one long string offered back to back, so a receiver hold-off fills the block
		for (int i = 0; i < LONG_STRING; i++)
			add_byte(8'($urandom_range(1, 127)), i == LONG_STRING - 1, 0, i == 0);

		for (int s = 0; random_bytes < RANDOM_BYTES; s++)
			add_random_string((s / 16) % 3, (s % 37) == 0);
		total_bytes = byte_q.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		wait (bytes_sent == total_bytes);
		wait (words_checked == words_predicted);
		repeat (SETTLE) @(posedge clk);
		if (words_checked != words_predicted) begin
			$display("%0t: %0d expected words never arrived", $time,
				words_predicted - words_checked);
			fail_count++;
		end

		$display("Sent %0d strings in %0d bytes (%0d random), checked %0d result words.",
			strings_total, total_bytes, random_bytes, words_checked);
		$display("Covered all byte classes, zero and truncated endings, long stalls, drains.");
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#1_000_000;
		$display("%0t: timeout", $time);
		$display("TB_ERROR");
		$finish;
	end

endmodule
